[src/c3lb_pkg.sv]
// ----------------------------------------------------------------------------
// c3lb_pkg: shared types and constants
// beat layouts, action and register codes, configuration defaults and the
// classified item that travels from the front end to the engine
// ----------------------------------------------------------------------------
package c3lb_pkg;

   localparam int DATA_BITS         = 16;
   localparam int KERNEL_SIZE       = 3;
   localparam int NUM_TAPS          = KERNEL_SIZE * KERNEL_SIZE;
   localparam int ACC_BITS          = 40;
   localparam int FRAC_BITS         = 8;
   localparam int MAX_USED_CHANNELS = 16;
   localparam int MAX_TILE_ROWS     = 256;
   localparam int MIN_TILE_SIZE     = 3;
   localparam int QUEUE_DEPTH       = 2;

   localparam int DEF_IN_CHANNELS   = 16;
   localparam int DEF_OUT_CHANNELS  = 16;
   localparam int DEF_MAX_TILE_COLS = 64;

   // action codes
   localparam logic [1:0] ACT_LOAD_WEIGHT = 2'd0;
   localparam logic [1:0] ACT_LOAD_BIAS   = 2'd1;
   localparam logic [1:0] ACT_PIXEL       = 2'd2;
   localparam logic [1:0] ACT_RESTART     = 2'd3;

   // register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_CHANNELS_USED = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RELU_ENABLE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUAL_ENABLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_COLS        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TILE_ROWS        = 3'd4;

   typedef struct packed {
      logic [1:0]                  action;
      logic [3:0]                  in_channel;
      logic [3:0]                  out_channel;
      logic [3:0]                  tap;
      logic signed [DATA_BITS-1:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0]                  out_channel_index;
      logic [7:0]                  out_row;
      logic [5:0]                  out_col;
      logic signed [DATA_BITS-1:0] conv_value;
      logic signed [DATA_BITS-1:0] sum_value;
      logic                        last;
   } rsp_type;

   typedef struct packed {
      logic [4:0] in_channels_used;
      logic       relu_enable;
      logic       residual_enable;
      logic [6:0] tile_cols;
      logic [8:0] tile_rows;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      in_channels_used: 5'd16,
      relu_enable:      1'b1,
      residual_enable:  1'b1,
      tile_cols:        7'd34,
      tile_rows:        9'd34
   };

   typedef enum logic [1:0] {
      KIND_WEIGHT,
      KIND_BIAS,
      KIND_PIXEL,
      KIND_RESTART
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     in_range;
      req_type  req;
   } item_type;

endpackage

[src/c3lb_front.sv]
// ----------------------------------------------------------------------------
// c3lb_front: input front end
// takes request beats, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module c3lb_front import c3lb_pkg::*; #(
   parameter int IN_CHANNELS  = DEF_IN_CHANNELS,
   parameter int OUT_CHANNELS = DEF_OUT_CHANNELS
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  req_type  req_data,
   input  logic     hold,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          fifo_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   item_type          item_in;
   logic              push;

   // classify
   always_comb begin
      item_in.req = req_data;
      unique case (req_data.action)
         ACT_LOAD_WEIGHT: begin
            item_in.kind     = KIND_WEIGHT;
            item_in.in_range = (int'(req_data.in_channel) < IN_CHANNELS) &&
                               (int'(req_data.out_channel) < OUT_CHANNELS) &&
                               (int'(req_data.tap) < NUM_TAPS);
         end
         ACT_LOAD_BIAS: begin
            item_in.kind     = KIND_BIAS;
            item_in.in_range = int'(req_data.out_channel) < OUT_CHANNELS;
         end
         ACT_PIXEL: begin
            item_in.kind     = KIND_PIXEL;
            item_in.in_range = int'(req_data.in_channel) < IN_CHANNELS;
         end
         ACT_RESTART: begin
            item_in.kind     = KIND_RESTART;
            item_in.in_range = 1'b1;
         end
      endcase
   end

   assign req_stall = hold || (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = count_ff != '0;
   assign q_item    = fifo_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (q_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         unique case ({push, q_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

[src/c3lb_back.sv]
// ----------------------------------------------------------------------------
// c3lb_back: convolution engine
// line and window stores, weight rows, sixteen-lane tap-serial mac and the
// result sequencer with rounding, relu, residual and saturation
// ----------------------------------------------------------------------------
module c3lb_back import c3lb_pkg::*; #(
   parameter int IN_CHANNELS   = DEF_IN_CHANNELS,
   parameter int OUT_CHANNELS  = DEF_OUT_CHANNELS,
   parameter int MAX_TILE_COLS = DEF_MAX_TILE_COLS
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     clear_busy,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int D          = DATA_BITS;
   localparam int CH_W       = (IN_CHANNELS > 1) ? $clog2(IN_CHANNELS) : 1;
   localparam int OC_W       = (OUT_CHANNELS > 1) ? $clog2(OUT_CHANNELS) : 1;
   localparam int LINE_DEPTH = IN_CHANNELS * MAX_TILE_COLS;
   localparam int LADDR_W    = $clog2(LINE_DEPTH);
   localparam int WROWS      = IN_CHANNELS * NUM_TAPS;
   localparam int WADDR_W    = $clog2(WROWS);
   localparam int PROD_W     = 2 * D;
   localparam int TOT_W      = ACC_BITS + 2;
   localparam int Q_W        = TOT_W - FRAC_BITS;
   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MAC,
      ST_POST,
      ST_EMIT
   } state_type;

   function automatic logic signed [D-1:0] sat_q(input logic signed [Q_W-1:0] v);
      logic same;
      same = (&v[Q_W-1:D-1]) || !(|v[Q_W-1:D-1]);
      if (same) begin
         return v[D-1:0];
      end
      return v[Q_W-1] ? {1'b1, {(D-1){1'b0}}} : {1'b0, {(D-1){1'b1}}};
   endfunction

   function automatic logic signed [D-1:0] sat_s(input logic signed [D:0] v);
      if (v[D] == v[D-1]) begin
         return v[D-1:0];
      end
      return v[D] ? {1'b1, {(D-1){1'b0}}} : {1'b0, {(D-1){1'b1}}};
   endfunction

   // memories
   logic [2*D-1:0]        line_mem [LINE_DEPTH];
   logic [NUM_TAPS*D-1:0] win_mem  [IN_CHANNELS];
   logic [OUT_CHANNELS*D-1:0] wgt_mem [WROWS];
   logic [2*D-1:0]        line_rd_ff;
   logic [NUM_TAPS*D-1:0] win_rd_ff;
   logic                  win_rd_valid_ff;
   logic [OUT_CHANNELS*D-1:0] wgt_rd_ff;
   logic signed [D-1:0]   bias_ff [OUT_CHANNELS];

   // control and lanes
   state_type             state_ff;
   item_type              cur_ff;
   logic [3:0]            tap_ff;
   logic [6:0]            col_ff;
   logic [8:0]            row_ff;
   logic [3:0]            chan_ff;
   logic [OC_W-1:0]       m_ff;
   logic                  clearing_ff;
   logic [LADDR_W-1:0]    clr_addr_ff;
   logic                  win_valid_ff [IN_CHANNELS];
   logic signed [D-1:0]   centre_ff [IN_CHANNELS];
   logic [ACC_BITS-1:0]   acc_ff [OUT_CHANNELS];
   logic signed [D-1:0]   win_ff [NUM_TAPS];
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic [4:0]            used_cnt;
   logic [6:0]            cols_lim;
   logic [8:0]            rows_lim;
   logic [6:0]            col_adj, col_next;
   logic [8:0]            row_adj, row_next;
   logic [LADDR_W-1:0]    line_raddr, line_waddr;
   logic                  line_we;
   logic [2*D-1:0]        line_wdata;
   logic [WADDR_W-1:0]    wgt_raddr, wgt_waddr;
   logic [3:0]            wtap;
   logic signed [D-1:0]   win_old [NUM_TAPS];
   logic signed [D-1:0]   win_new [NUM_TAPS];
   logic [NUM_TAPS*D-1:0] win_wdata;
   logic signed [D-1:0]   win_tap;
   logic [ACC_BITS-1:0]   acc_sum [OUT_CHANNELS];
   logic                  out_free;
   logic                  emit_fire;
   logic                  load_w, load_b;
   rsp_type               result;
   logic [ACC_BITS-1:0]   acc_sel;
   logic signed [D-1:0]   bias_sel;
   logic signed [D-1:0]   centre_sel;
   logic [TOT_W-1:0]      total;
   logic signed [Q_W-1:0] q_val;
   logic signed [D-1:0]   conv_val;

   assign clear_busy = clearing_ff;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid && !clearing_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign emit_fire  = (state_ff == ST_EMIT) && out_free;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign load_w     = q_pop && (q_item.kind == KIND_WEIGHT) && q_item.in_range;
   assign load_b     = q_pop && (q_item.kind == KIND_BIAS) && q_item.in_range;

   // clamped register values
   always_comb begin
      if (cfg.in_channels_used == 5'd0) begin
         used_cnt = 5'd1;
      end else if (int'(cfg.in_channels_used) > MAX_USED_CHANNELS) begin
         used_cnt = 5'(MAX_USED_CHANNELS);
      end else begin
         used_cnt = cfg.in_channels_used;
      end
      if (int'(used_cnt) > IN_CHANNELS) begin
         used_cnt = 5'(IN_CHANNELS);
      end
      if (int'(cfg.tile_cols) < MIN_TILE_SIZE) begin
         cols_lim = 7'(MIN_TILE_SIZE);
      end else if (int'(cfg.tile_cols) > MAX_TILE_COLS) begin
         cols_lim = 7'(MAX_TILE_COLS);
      end else begin
         cols_lim = cfg.tile_cols;
      end
      if (int'(cfg.tile_rows) < MIN_TILE_SIZE) begin
         rows_lim = 9'(MIN_TILE_SIZE);
      end else if (int'(cfg.tile_rows) > MAX_TILE_ROWS) begin
         rows_lim = 9'(MAX_TILE_ROWS);
      end else begin
         rows_lim = cfg.tile_rows;
      end
   end

   // position counters: wrap before a sample, advance after a position
   always_comb begin
      col_adj = col_ff;
      row_adj = row_ff;
      if (col_adj >= cols_lim) begin
         col_adj = '0;
         row_adj = row_adj + 9'd1;
      end
      if (row_adj >= rows_lim) begin
         row_adj = '0;
      end
      col_next = col_ff + 7'd1;
      row_next = row_ff;
      if (col_next >= cols_lim) begin
         col_next = '0;
         row_next = row_ff + 9'd1;
         if (row_next >= rows_lim) begin
            row_next = '0;
         end
      end
   end

   // line store: low half holds the older row
   always_comb begin
      line_raddr = LADDR_W'(int'(q_item.req.in_channel) * MAX_TILE_COLS + int'(col_adj));
      line_we    = clearing_ff || (state_ff == ST_READ);
      if (clearing_ff) begin
         line_waddr = clr_addr_ff;
         line_wdata = '0;
      end else begin
         line_waddr = LADDR_W'(int'(cur_ff.req.in_channel) * MAX_TILE_COLS + int'(col_ff));
         line_wdata = {cur_ff.req.value, line_rd_ff[2*D-1:D]};
      end
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_mem[line_waddr] <= line_wdata;
      end
      line_rd_ff <= line_mem[line_raddr];
   end

   // window shift
   always_comb begin
      for (int t = 0; t < NUM_TAPS; t++) begin
         win_old[t] = win_rd_valid_ff ? win_rd_ff[t*D +: D] : '0;
      end
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         win_new[r*3]     = win_old[r*3 + 1];
         win_new[r*3 + 1] = win_old[r*3 + 2];
      end
      win_new[2] = line_rd_ff[D-1:0];
      win_new[5] = line_rd_ff[2*D-1:D];
      win_new[8] = cur_ff.req.value;
      for (int t = 0; t < NUM_TAPS; t++) begin
         win_wdata[t*D +: D] = win_new[t];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_READ) begin
         win_mem[CH_W'(cur_ff.req.in_channel)] <= win_wdata;
      end
      win_rd_ff <= win_mem[CH_W'(q_item.req.in_channel)];
   end

   // weight rows: one row of all output lanes per input channel and tap
   always_comb begin
      wtap = '0;
      if ((state_ff == ST_MAC) && (int'(tap_ff) < NUM_TAPS - 1)) begin
         wtap = tap_ff + 4'd1;
      end
      wgt_raddr = WADDR_W'(int'(cur_ff.req.in_channel) * NUM_TAPS + int'(wtap));
      wgt_waddr = WADDR_W'(int'(q_item.req.in_channel) * NUM_TAPS + int'(q_item.req.tap));
   end

   always_ff @(posedge clock) begin
      if (load_w) begin
         wgt_mem[wgt_waddr][int'(q_item.req.out_channel)*D +: D] <= q_item.req.value;
      end
      wgt_rd_ff <= wgt_mem[wgt_raddr];
      if (load_b) begin
         bias_ff[OC_W'(q_item.req.out_channel)] <= q_item.req.value;
      end
   end

   // mac lanes
   always_comb begin
      win_tap = win_ff[tap_ff];
      for (int m = 0; m < OUT_CHANNELS; m++) begin
         logic signed [PROD_W-1:0] prod;
         prod       = $signed(wgt_rd_ff[m*D +: D]) * win_tap;
         acc_sum[m] = acc_ff[m] + {{(ACC_BITS-PROD_W){prod[PROD_W-1]}}, prod};
      end
   end

   // result of output lane m
   always_comb begin
      acc_sel    = acc_ff[m_ff];
      bias_sel   = bias_ff[m_ff];
      centre_sel = '0;
      if (int'(m_ff) < IN_CHANNELS) begin
         centre_sel = centre_ff[CH_W'(m_ff)];
      end
      total = {{2{acc_sel[ACC_BITS-1]}}, acc_sel}
            + {{(TOT_W-D-FRAC_BITS){bias_sel[D-1]}}, bias_sel, {FRAC_BITS{1'b0}}}
            + TOT_W'(ROUND_HALF);
      q_val = total[TOT_W-1:FRAC_BITS];
      if (cfg.relu_enable && q_val[Q_W-1]) begin
         q_val = '0;
      end
      conv_val = sat_q(q_val);
      result.out_channel_index = 4'(m_ff);
      result.out_row    = 8'(row_ff - 9'd2);
      result.out_col    = 6'(col_ff - 7'd2);
      result.conv_value = conv_val;
      result.sum_value  = cfg.residual_enable
                        ? sat_s({conv_val[D-1], conv_val} + {centre_sel[D-1], centre_sel})
                        : conv_val;
      result.last       = m_ff == OC_W'(OUT_CHANNELS - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         chan_ff      <= '0;
         m_ff         <= '0;
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < IN_CHANNELS; c++) begin
            win_valid_ff[c] <= 1'b0;
            centre_ff[c]    <= '0;
         end
         for (int m = 0; m < OUT_CHANNELS; m++) begin
            acc_ff[m] <= '0;
         end
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == LADDR_W'(LINE_DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         win_rd_valid_ff <= win_valid_ff[CH_W'(q_item.req.in_channel)];
         // a result beat stays until taken, a new one is loaded when free
         rsp_valid_ff <= emit_fire || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  cur_ff <= q_item;
                  unique case (q_item.kind)
                     KIND_PIXEL: begin
                        col_ff   <= col_adj;
                        row_ff   <= row_adj;
                        state_ff <= q_item.in_range ? ST_READ : ST_POST;
                     end
                     KIND_RESTART: begin
                        col_ff  <= '0;
                        row_ff  <= '0;
                        chan_ff <= '0;
                        for (int m = 0; m < OUT_CHANNELS; m++) begin
                           acc_ff[m] <= '0;
                        end
                     end
                     KIND_WEIGHT, KIND_BIAS: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_READ: begin
               for (int t = 0; t < NUM_TAPS; t++) begin
                  win_ff[t] <= win_new[t];
               end
               win_valid_ff[CH_W'(cur_ff.req.in_channel)] <= 1'b1;
               centre_ff[CH_W'(cur_ff.req.in_channel)]    <= win_new[4];
               tap_ff   <= '0;
               state_ff <= ST_MAC;
            end
            ST_MAC: begin
               for (int m = 0; m < OUT_CHANNELS; m++) begin
                  acc_ff[m] <= acc_sum[m];
               end
               if (int'(tap_ff) == NUM_TAPS - 1) begin
                  state_ff <= ST_POST;
               end else begin
                  tap_ff <= tap_ff + 4'd1;
               end
            end
            ST_POST: begin
               if ({1'b0, chan_ff} + 5'd1 < used_cnt) begin
                  chan_ff  <= chan_ff + 4'd1;
                  state_ff <= ST_IDLE;
               end else begin
                  chan_ff <= '0;
                  if ((row_ff >= 9'd2) && (col_ff >= 7'd2)) begin
                     m_ff     <= '0;
                     state_ff <= ST_EMIT;
                  end else begin
                     for (int m = 0; m < OUT_CHANNELS; m++) begin
                        acc_ff[m] <= '0;
                     end
                     col_ff   <= col_next;
                     row_ff   <= row_next;
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_ff <= result;
                  if (result.last) begin
                     for (int m = 0; m < OUT_CHANNELS; m++) begin
                        acc_ff[m] <= '0;
                     end
                     col_ff   <= col_next;
                     row_ff   <= row_next;
                     state_ff <= ST_IDLE;
                  end else begin
                     m_ff <= m_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[src/conv3x3_line_buffer_relu_residual_core.sv]
// ----------------------------------------------------------------------------
// conv3x3_line_buffer_relu_residual_core: streaming 3x3 convolution
// multi-channel 3x3 convolution with bias, relu and residual add
// ----------------------------------------------------------------------------
// steps: a pixel beat goes through queue pop, line and window read, a tap-serial
//   mac over the nine taps on the 16 lane multipliers and the channel count; the
//   last channel of an inner position adds one result beat per output channel
// flow: the engine takes no new beat until the last is done (results included);
//   loads and restarts finish at the pop
// reset: synchronous; a clearing pass over the IN_CHANNELS*MAX_TILE_COLS entries
//   (1024 by default) zeroes the line store, req_stall stays high meanwhile
module conv3x3_line_buffer_relu_residual_core import c3lb_pkg::*; #(
   parameter int IN_CHANNELS   = DEF_IN_CHANNELS,
   parameter int OUT_CHANNELS  = DEF_OUT_CHANNELS,
   parameter int MAX_TILE_COLS = DEF_MAX_TILE_COLS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   cfg_type  cfg_ff;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;
   logic     clear_busy;

   // configuration regs: user writes only while the block is idle; not enforced
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IN_CHANNELS_USED: cfg_ff.in_channels_used <= csr_write_data[4:0];
            CSR_RELU_ENABLE:      cfg_ff.relu_enable      <= csr_write_data[0];
            CSR_RESIDUAL_ENABLE:  cfg_ff.residual_enable  <= csr_write_data[0];
            CSR_TILE_COLS:        cfg_ff.tile_cols        <= csr_write_data[6:0];
            CSR_TILE_ROWS:        cfg_ff.tile_rows        <= csr_write_data[8:0];
            default:              cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   // front end: classify and queue beats
   c3lb_front #(
      .IN_CHANNELS  (IN_CHANNELS),
      .OUT_CHANNELS (OUT_CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .hold      (clear_busy),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   // engine: stores, mac lanes and result sequencer
   c3lb_back #(
      .IN_CHANNELS   (IN_CHANNELS),
      .OUT_CHANNELS  (OUT_CHANNELS),
      .MAX_TILE_COLS (MAX_TILE_COLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .clear_busy (clear_busy),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // no beat enters while the line store is being cleared
   a_clear_blocks_input: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> req_stall)
      else $error("beat accepted during line store clear");

   // the engine only pops what the queue holds
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

   // last marks the final output channel of a position
   a_last_channel: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> (rsp_data.out_channel_index == 4'(OUT_CHANNELS - 1)))
      else $error("last on wrong output channel");

endmodule

[bench/conv3x3_line_buffer_relu_residual_core_tb.sv]
// ----------------------------------------------------------------------------
// conv3x3_line_buffer_relu_residual_core_tb: self-checking bench for the core
// loads every bias and the weights of input channels 0 and 1, then streams
// small padded tiles on those channels under several register settings and
// idle patterns; a tile model in the bench predicts each result beat and a
// monitor compares field by field
// ----------------------------------------------------------------------------
module conv3x3_line_buffer_relu_residual_core_tb;
   import c3lb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   conv3x3_line_buffer_relu_residual_core dut (.*);

   // 12 ns clock
   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   // tile model state
   logic signed [15:0] weights [16][16][NUM_TAPS];
   logic signed [15:0] biases [16];
   logic signed [15:0] lines [16][2][64];
   logic signed [15:0] windows [16][NUM_TAPS];
   logic [39:0]        accs [16];
   int                 col_cnt, row_cnt, chan_cnt;
   cfg_type            cfg_mirror;

   rsp_type expected_beats [$];
   int      mismatches;
   int      idle_pct;
   int      stall_pct;

   // ---------------------------------------------------------------- model
   function automatic logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic void clear_position_state();
      col_cnt = 0;
      row_cnt = 0;
      chan_cnt = 0;
      foreach (accs[m]) accs[m] = '0;
   endfunction

   // apply one accepted beat to the tile model and queue the results it makes
   function automatic void predict_tile_beat(req_type b);
      int      used, cols, rows, x, ic;
      longint  prod, total, q, conv;
      rsp_type r;
      case (b.action)
         ACT_LOAD_WEIGHT: begin
            if (b.tap < NUM_TAPS) weights[b.out_channel][b.in_channel][b.tap] = b.value;
         end
         ACT_LOAD_BIAS:   biases[b.out_channel] = b.value;
         ACT_RESTART:     clear_position_state();
         default: begin
            used = int'(cfg_mirror.in_channels_used);
            if (used < 1) used = 1;
            if (used > 16) used = 16;
            cols = int'(cfg_mirror.tile_cols);
            if (cols < 3) cols = 3;
            if (cols > 64) cols = 64;
            rows = int'(cfg_mirror.tile_rows);
            if (rows < 3) rows = 3;
            if (rows > 256) rows = 256;
            // counters beyond a shrunken tile wrap first
            if (col_cnt >= cols) begin
               col_cnt = 0;
               row_cnt++;
            end
            if (row_cnt >= rows) row_cnt = 0;
            x = col_cnt;
            ic = int'(b.in_channel);
            // shift the window left, pull the column in from the line buffers
            for (int t = 0; t < 3; t++) begin
               windows[ic][t*3] = windows[ic][t*3+1];
               windows[ic][t*3+1] = windows[ic][t*3+2];
            end
            windows[ic][2] = lines[ic][0][x];
            windows[ic][5] = lines[ic][1][x];
            lines[ic][0][x] = lines[ic][1][x];
            lines[ic][1][x] = b.value;
            windows[ic][8] = b.value;
            for (int m = 0; m < 16; m++)
               for (int t = 0; t < NUM_TAPS; t++) begin
                  prod = longint'(weights[m][ic][t]) * longint'(windows[ic][t]);
                  accs[m] = accs[m] + prod[39:0];
               end
            if (chan_cnt + 1 < used) begin
               chan_cnt++;
               return;
            end
            chan_cnt = 0;
            // inner positions only; borders just fill the buffers
            if (row_cnt >= 2 && col_cnt >= 2) begin
               for (int m = 0; m < 16; m++) begin
                  total = longint'($signed(accs[m])) + longint'(biases[m]) * 256 + 128;
                  q = total >>> FRAC_BITS;
                  if (cfg_mirror.relu_enable && q < 0) q = 0;
                  conv = longint'(sat16(q));
                  r.out_channel_index = 4'(m);
                  r.out_row = 8'(row_cnt - 2);
                  r.out_col = 6'(col_cnt - 2);
                  r.conv_value = conv[15:0];
                  r.sum_value = cfg_mirror.residual_enable ?
                                sat16(conv + longint'(windows[m][4])) : conv[15:0];
                  r.last = (m == 15);
                  expected_beats.push_back(r);
               end
            end
            foreach (accs[m]) accs[m] = '0;
            col_cnt++;
            if (col_cnt >= cols) begin
               col_cnt = 0;
               row_cnt++;
               if (row_cnt >= rows) row_cnt = 0;
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------- checking
   task automatic report_mismatch(string what, int got, int want);
      if (mismatches < 40)
         $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   rsp_type want_beat;
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected result beat, channel",
                            int'(rsp_data.out_channel_index), -1);
         end else begin
            want_beat = expected_beats.pop_front();
            if (rsp_data.out_channel_index !== want_beat.out_channel_index)
               report_mismatch("out_channel_index", int'(rsp_data.out_channel_index),
                               int'(want_beat.out_channel_index));
            if (rsp_data.out_row !== want_beat.out_row)
               report_mismatch("out_row", int'(rsp_data.out_row), int'(want_beat.out_row));
            if (rsp_data.out_col !== want_beat.out_col)
               report_mismatch("out_col", int'(rsp_data.out_col), int'(want_beat.out_col));
            if (rsp_data.conv_value !== want_beat.conv_value)
               report_mismatch("conv_value", int'(rsp_data.conv_value),
                               int'(want_beat.conv_value));
            if (rsp_data.sum_value !== want_beat.sum_value)
               report_mismatch("sum_value", int'(rsp_data.sum_value),
                               int'(want_beat.sum_value));
            if (rsp_data.last !== want_beat.last)
               report_mismatch("last", int'(rsp_data.last), int'(want_beat.last));
         end
      end
   end

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // -------------------------------------------------------------- drivers
   // one beat on the request channel; the model is updated on acceptance
   task automatic send_beat(req_type b);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_stall);
      predict_tile_beat(b);
   endtask

   // wait until all results are back, then let a pixel with no result finish
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, int data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_IN_CHANNELS_USED: cfg_mirror.in_channels_used = data[4:0];
         CSR_RELU_ENABLE:      cfg_mirror.relu_enable = data[0];
         CSR_RESIDUAL_ENABLE:  cfg_mirror.residual_enable = data[0];
         CSR_TILE_COLS:        cfg_mirror.tile_cols = data[6:0];
         CSR_TILE_ROWS:        cfg_mirror.tile_rows = data[8:0];
         default: ;
      endcase
   endtask

   task automatic set_tile(int used, int relu, int resid, int cols, int rows);
      wait_idle();
      write_register(CSR_IN_CHANNELS_USED, used);
      write_register(CSR_RELU_ENABLE, relu);
      write_register(CSR_RESIDUAL_ENABLE, resid);
      write_register(CSR_TILE_COLS, cols);
      write_register(CSR_TILE_ROWS, rows);
   endtask

   // mostly small q8.8 values so sums stay in range, some full-scale ones
   function automatic logic signed [15:0] pick_value();
      case ($urandom_range(9))
         0:       return 16'($urandom());
         1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         default: return $signed(16'($urandom_range(1023))) - 16'sd512;
      endcase
   endfunction

   function automatic req_type make_beat(logic [1:0] act, int ic, int oc, int tp,
                                         logic signed [15:0] v);
      req_type b;
      b.action = act;
      b.in_channel = 4'(ic);
      b.out_channel = 4'(oc);
      b.tap = 4'(tp);
      b.value = v;
      return b;
   endfunction

   // random request: mostly pixels on the loaded channels, mostly in sequence
   task automatic send_random_beat();
      int pick, ic;
      pick = $urandom_range(99);
      ic = (pick < 80) ? (chan_cnt % 2) : int'($urandom_range(1));
      if (pick < 90)
         send_beat(make_beat(ACT_PIXEL, ic, $urandom_range(15), $urandom_range(15),
                             pick_value()));
      else if (pick < 95)
         send_beat(make_beat(ACT_LOAD_WEIGHT, $urandom_range(15), $urandom_range(15),
                             $urandom_range(15), pick_value()));
      else if (pick < 98)
         send_beat(make_beat(ACT_LOAD_BIAS, $urandom_range(15), $urandom_range(15),
                             $urandom_range(15), pick_value()));
      else
         send_beat(make_beat(ACT_RESTART, $urandom_range(15), $urandom_range(15),
                             $urandom_range(15), 16'($urandom())));
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_load_stores();
      for (int oc = 0; oc < 16; oc++) begin
         send_beat(make_beat(ACT_LOAD_BIAS, $urandom_range(15), oc, $urandom_range(15),
                             pick_value()));
         for (int ic = 0; ic < 2; ic++)
            for (int t = 0; t < NUM_TAPS; t++)
               send_beat(make_beat(ACT_LOAD_WEIGHT, ic, oc, t, pick_value()));
      end
   endtask

   // one inner position with full-scale pixels, relu and residual both ways
   task automatic test_directed_extremes();
      logic signed [15:0] px [9] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'sh0001,
                                     16'shffff, 16'sh7fff, 16'sh8000, 16'sh0100,
                                     16'sh7fff};
      set_tile(1, 1, 1, 3, 3);
      foreach (px[i]) send_beat(make_beat(ACT_PIXEL, 0, 0, 0, px[i]));
      set_tile(1, 0, 0, 3, 3);
      foreach (px[i]) send_beat(make_beat(ACT_PIXEL, 0, 15, 15, -px[i]));
      // taps beyond the kernel are dropped, restart clears mid-tile
      send_beat(make_beat(ACT_LOAD_WEIGHT, 15, 15, 9, 16'sh7fff));
      send_beat(make_beat(ACT_LOAD_WEIGHT, 0, 0, 15, 16'sh8000));
      send_beat(make_beat(ACT_PIXEL, 0, 0, 0, 16'sh0040));
      send_beat(make_beat(ACT_RESTART, 0, 0, 0, 16'sh0000));
   endtask

   // repeated channels and channels in either order
   task automatic test_channel_order();
      set_tile(2, 1, 1, 3, 4);
      repeat (24) send_beat(make_beat(ACT_PIXEL, $urandom_range(1) ? 1 : 0, 0, 0,
                                      pick_value()));
   endtask

   // out-of-range register values saturate; shrinking wraps the counters
   task automatic test_register_range();
      set_tile(0, 1, 0, 2, 1);
      repeat (6) send_random_beat();
      set_tile(31, 0, 1, 127, 511);
      repeat (8) send_random_beat();
      set_tile(1, 1, 1, 4, 3);
      repeat (12) send_beat(make_beat(ACT_PIXEL, 0, 0, 0, pick_value()));
      set_tile(2, 0, 1, 3, 5);
      repeat (30) send_beat(make_beat(ACT_PIXEL, chan_cnt % 2, 0, 0, pick_value()));
      set_tile(1, 1, 1, 3, 3);
   endtask

   task automatic test_random_tiles(int beats);
      int sent;
      sent = 0;
      while (sent < beats) begin
         set_tile($urandom_range(1, 4), $urandom_range(1), $urandom_range(1),
                  $urandom_range(3, 8), $urandom_range(3, 6));
         repeat (7) send_random_beat();
         sent += 7;
      end
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      idle_pct = 0;
      stall_pct = 0;
      mismatches = 0;
      cfg_mirror = CFG_RESET;
      foreach (lines[i, j, k]) lines[i][j][k] = '0;
      foreach (windows[i, j]) windows[i][j] = '0;
      clear_position_state();
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_load_stores();
      test_directed_extremes();
      test_channel_order();
      test_register_range();
      // idle patterns: none, sender gaps, receiver stalls, both
      idle_pct = 0;  stall_pct = 0;  test_random_tiles(14);
      idle_pct = 79; stall_pct = 0;  test_random_tiles(14);
      idle_pct = 0;  stall_pct = 79; test_random_tiles(14);
      idle_pct = 31; stall_pct = 31; test_random_tiles(14);

      wait_idle();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

endmodule

[conv3x3_line_buffer_relu_residual_core.f]
src/c3lb_pkg.sv
src/c3lb_front.sv
src/c3lb_back.sv
src/conv3x3_line_buffer_relu_residual_core.sv
bench/conv3x3_line_buffer_relu_residual_core_tb.sv
